// ----- design/sao_pkg.sv -----
// Shared types and constants for the straight-alpha over blender.
// No dependencies; imported by every module of the block.
package sao_pkg;

  localparam int CHAN_W    = 16;
  localparam int NUM_CH    = 3;                 // red, green, blue
  localparam int WEIGHT_W  = 2 * CHAN_W;        // W <= 65535^2 fits in 32 bits
  localparam int NUM_W     = 3 * CHAN_W;        // color numerator
  localparam int DIV_STEPS = CHAN_W;            // one quotient bit per stage

  localparam logic [CHAN_W-1:0] FULL_SCALE = '1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [NUM_CH-1:0] rgb_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef num_t [NUM_CH-1:0] rgb_num_t;

  // Hand-off from the weighting front end to the divider.
  typedef struct packed {
    rgb_num_t num;     // cS*sW + cD*dW per channel
    weight_t  weight;  // W, the common divisor
    chan_t    alpha;   // floor(W / 65535)
    logic     clear;   // W == 0: colors forced to zero
  } front_t;

endpackage

// ----- design/sao_front.sv -----
// Weighting front end: alpha weights, color products and numerator sums, output alpha.
// Three register stages; depends on sao_pkg.
module sao_front
  import sao_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  rgb_t   src_rgb,
  input  chan_t  src_alpha,
  input  rgb_t   dst_rgb,
  input  chan_t  dst_alpha,
  output logic   front_valid,
  output front_t front
);

  // stage 1: weights
  logic    v1;
  weight_t src_w1;
  weight_t dst_w1;
  rgb_t    cs1;
  rgb_t    cd1;

  // stage 2: products
  logic     v2;
  weight_t  w2;
  rgb_num_t ps2;
  rgb_num_t pd2;

  // stage 3: sums and alpha
  logic   v3;
  front_t f3;

  weight_t                src_w_next;
  weight_t                dst_w_next;
  rgb_num_t               ps_next;
  rgb_num_t               pd_next;
  rgb_num_t               num_next;
  logic [CHAN_W:0]        fold_sum;
  logic [1:0]             fold_corr;
  chan_t                  alpha_next;

  always_comb begin
    // sA*65535 as a shift and subtract; 65535 - sA is the complement
    src_w_next = {src_alpha, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, src_alpha};
    dst_w_next = weight_t'(dst_alpha * (FULL_SCALE ^ src_alpha));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      src_w1 <= src_w_next;
      dst_w1 <= dst_w_next;
      cs1    <= src_rgb;
      cd1    <= dst_rgb;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ps_next[c] = num_t'(cs1[c] * src_w1);
      pd_next[c] = num_t'(cd1[c] * dst_w1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w2  <= src_w1 + dst_w1;
      ps2 <= ps_next;
      pd2 <= pd_next;
    end
  end

  // W = hi*65536 + lo = hi*65535 + (hi + lo), and hi + lo stays below 3*65535
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      num_next[c] = ps2[c] + pd2[c];
    end
    fold_sum = {1'b0, w2[WEIGHT_W-1:CHAN_W]} + {1'b0, w2[CHAN_W-1:0]};
    if (fold_sum >= {FULL_SCALE, 1'b0}) begin
      fold_corr = 2'd2;
    end else if (fold_sum >= {1'b0, FULL_SCALE}) begin
      fold_corr = 2'd1;
    end else begin
      fold_corr = 2'd0;
    end
    alpha_next = w2[WEIGHT_W-1:CHAN_W] + chan_t'(fold_corr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3.num    <= num_next;
      f3.weight <= w2;
      f3.alpha  <= alpha_next;
      f3.clear  <= (w2 == '0);
    end
  end

  assign front_valid = v3;
  assign front       = f3;

  // the quotient must fit in 16 bits for the divider to be exact
  a_num_range: assert property (@(posedge clk) disable iff (rst)
    v3 && !f3.clear |-> (f3.num[0][NUM_W-1:CHAN_W] < f3.weight) &&
                        (f3.num[1][NUM_W-1:CHAN_W] < f3.weight) &&
                        (f3.num[2][NUM_W-1:CHAN_W] < f3.weight))
    else $error("color numerator exceeds 16-bit quotient range");

  // a zero weight only comes with zero alpha
  a_clear_alpha: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (f3.clear == (f3.alpha == '0)))
    else $error("zero-weight flag disagrees with alpha");

endmodule

// ----- design/sao_divider.sv -----
// Pipelined restoring divider: one quotient bit per stage for all three channels.
// Shares the weight as divisor; depends on sao_pkg.
module sao_divider
  import sao_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   front_valid,
  input  front_t front,
  output logic   div_valid,
  output rgb_t   quot,
  output chan_t  alpha,
  output logic   clear
);

  logic [DIV_STEPS:1] vld;
  weight_t            dvsr   [1:DIV_STEPS];
  chan_t              alph   [1:DIV_STEPS];
  logic               clr    [1:DIV_STEPS];
  weight_t            rem    [1:DIV_STEPS][NUM_CH];
  chan_t              nq     [1:DIV_STEPS][NUM_CH];

  // one restoring step: MSB is the quotient bit, the rest the new remainder
  function automatic logic [WEIGHT_W:0] div_step(input weight_t r, input logic b,
                                                 input weight_t d);
    logic [WEIGHT_W:0] t;
    logic [WEIGHT_W:0] diff;
    t    = {r, b};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, diff[WEIGHT_W-1:0]};
    end else begin
      return {1'b0, t[WEIGHT_W-1:0]};
    end
  endfunction

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic              v_in;
    weight_t           d_in;
    chan_t             a_in;
    logic              c_in;
    weight_t           r_in [NUM_CH];
    chan_t             q_in [NUM_CH];
    logic [WEIGHT_W:0] res  [NUM_CH];

    // the first step reads the front end's output register
    if (k == 0) begin : g_src
      always_comb begin
        v_in = front_valid;
        d_in = front.weight;
        a_in = front.alpha;
        c_in = front.clear;
        for (int c = 0; c < NUM_CH; c++) begin
          r_in[c] = front.num[c][NUM_W-1:CHAN_W];
          q_in[c] = front.num[c][CHAN_W-1:0];
        end
      end
    end else begin : g_src
      always_comb begin
        v_in = vld[k];
        d_in = dvsr[k];
        a_in = alph[k];
        c_in = clr[k];
        for (int c = 0; c < NUM_CH; c++) begin
          r_in[c] = rem[k][c];
          q_in[c] = nq[k][c];
        end
      end
    end

    always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
        res[c] = div_step(r_in[c], q_in[c][CHAN_W-1], d_in);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= v_in;
      end
    end

    // shift the numerator bits out and the quotient bits in
    always_ff @(posedge clk) begin
      if (en) begin
        dvsr[k+1] <= d_in;
        alph[k+1] <= a_in;
        clr[k+1]  <= c_in;
        for (int c = 0; c < NUM_CH; c++) begin
          rem[k+1][c] <= res[c][WEIGHT_W-1:0];
          nq[k+1][c]  <= {q_in[c][CHAN_W-2:0], res[c][WEIGHT_W]};
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      quot[c] = nq[DIV_STEPS][c];
    end
  end

  assign div_valid = vld[DIV_STEPS];
  assign alpha     = alph[DIV_STEPS];
  assign clear     = clr[DIV_STEPS];

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_STEPS] && !clr[DIV_STEPS] |->
      (rem[DIV_STEPS][0] < dvsr[DIV_STEPS]) && (rem[DIV_STEPS][1] < dvsr[DIV_STEPS]) &&
      (rem[DIV_STEPS][2] < dvsr[DIV_STEPS]))
    else $error("final remainder not below divisor");

endmodule

// ----- design/straight_alpha_over_blend.sv -----
// Straight-alpha Porter-Duff over of two 16-bit RGBA pixels.
// Pipeline: 3 weighting stages, then 16 divider stages, from accepted input to result.
// Throughput: one pixel per cycle unless stalled; each divider stage resolves one quotient bit per channel.
// A stall freezes the whole pipeline; input stall follows a waiting, stalled result.
// Synchronous reset clears the valid bits only; datapath registers are not reset.
// Depends on sao_pkg, sao_front and sao_divider.
module straight_alpha_over_blend
  import sao_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  chan_t src_red,
  input  chan_t src_green,
  input  chan_t src_blue,
  input  chan_t src_alpha,
  input  chan_t dst_red,
  input  chan_t dst_green,
  input  chan_t dst_blue,
  input  chan_t dst_alpha,
  output logic  out_valid,
  input  logic  out_stall,
  output chan_t out_red,
  output chan_t out_green,
  output chan_t out_blue,
  output chan_t out_alpha
);

  logic   en;
  logic   front_valid;
  front_t front;
  logic   div_valid;
  rgb_t   quot;
  chan_t  alpha;
  logic   clear;

  // advance unless a finished transaction is held at the output
  assign en       = !(div_valid && out_stall);
  assign in_stall = !en;

  sao_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .src_rgb    ({src_blue, src_green, src_red}),
    .src_alpha  (src_alpha),
    .dst_rgb    ({dst_blue, dst_green, dst_red}),
    .dst_alpha  (dst_alpha),
    .front_valid(front_valid),
    .front      (front)
  );

  sao_divider u_divider (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .front_valid(front_valid),
    .front      (front),
    .div_valid  (div_valid),
    .quot       (quot),
    .alpha      (alpha),
    .clear      (clear)
  );

  // drop colors of a fully transparent result
  assign out_valid = div_valid;
  assign out_red   = clear ? '0 : quot[0];
  assign out_green = clear ? '0 : quot[1];
  assign out_blue  = clear ? '0 : quot[2];
  assign out_alpha = alpha;

  a_transparent: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_alpha == '0) |->
      (out_red == '0) && (out_green == '0) && (out_blue == '0))
    else $error("transparent result carries color");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ----- bench/straight_alpha_over_blend_tb.sv -----
// Self-checking bench for straight_alpha_over_blend: straight-alpha Porter-Duff over.
// Depends on sao_pkg (chan_t, FULL_SCALE) and the straight_alpha_over_blend RTL.
// Expected pixels come from an exact integer predictor and are checked in order.
module straight_alpha_over_blend_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sao_pkg::*;

  localparam int PIPE_LATENCY = 19;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } rgba_t;

  typedef struct packed {
    rgba_t src;
    rgba_t dst;
  } pixel_pair_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  chan_t src_red = '0;
  chan_t src_green = '0;
  chan_t src_blue = '0;
  chan_t src_alpha = '0;
  chan_t dst_red = '0;
  chan_t dst_green = '0;
  chan_t dst_blue = '0;
  chan_t dst_alpha = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  chan_t out_alpha;

  rgba_t blended_pixels[$];
  int    error_count = 0;
  int    result_count = 0;
  int    cycle_count = 0;
  bit    tx_idle_en = 1'b0;
  bit    rx_idle_en = 1'b0;
  bit    hold_request = 1'b0;

  straight_alpha_over_blend DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .src_red   (src_red),
    .src_green (src_green),
    .src_blue  (src_blue),
    .src_alpha (src_alpha),
    .dst_red   (dst_red),
    .dst_green (dst_green),
    .dst_blue  (dst_blue),
    .dst_alpha (dst_alpha),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One color channel: weighted mean of source and destination, clamped.
  function automatic chan_t blend_channel(chan_t cs, chan_t cd, longint unsigned sw,
                                          longint unsigned dw, longint unsigned w);
    longint unsigned q;
    if (w == 0) return '0;
    q = (longint'(cs) * sw + longint'(cd) * dw) / w;
    if (q > FULL_SCALE) q = FULL_SCALE;
    return chan_t'(q);
  endfunction

  function automatic rgba_t blend_over(pixel_pair_t p);
    longint unsigned full;
    longint unsigned sw;
    longint unsigned dw;
    longint unsigned w;
    longint unsigned a;
    rgba_t r;
    full = FULL_SCALE;
    sw = longint'(p.src.alpha) * full;
    dw = longint'(p.dst.alpha) * (full - longint'(p.src.alpha));
    w  = sw + dw;
    a  = w / full;
    if (a > full) a = full;
    r.red   = blend_channel(p.src.red, p.dst.red, sw, dw, w);
    r.green = blend_channel(p.src.green, p.dst.green, sw, dw, w);
    r.blue  = blend_channel(p.src.blue, p.dst.blue, sw, dw, w);
    r.alpha = chan_t'(a);
    return r;
  endfunction

  function automatic pixel_pair_t make_pair(chan_t sr, chan_t sg, chan_t sb, chan_t sa,
                                            chan_t dr, chan_t dg, chan_t db, chan_t da);
    pixel_pair_t p;
    p.src = '{sr, sg, sb, sa};
    p.dst = '{dr, dg, db, da};
    return p;
  endfunction

  // Favor the alpha corners: transparent, opaque and values right next to them.
  function automatic chan_t pick_alpha();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return FULL_SCALE;
      2:       return chan_t'($urandom_range(1, 255));
      3:       return FULL_SCALE - chan_t'($urandom_range(1, 255));
      default: return chan_t'($urandom);
    endcase
  endfunction

  function automatic chan_t pick_color();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return FULL_SCALE;
      default: return chan_t'($urandom);
    endcase
  endfunction

  function automatic pixel_pair_t random_pair();
    return make_pair(pick_color(), pick_color(), pick_color(), pick_alpha(),
                     pick_color(), pick_color(), pick_color(), pick_alpha());
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] result %0d: %s", $time, result_count, msg);
    error_count++;
  endtask

  task automatic send_pixel(pixel_pair_t p);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    src_red   <= p.src.red;
    src_green <= p.src.green;
    src_blue  <= p.src.blue;
    src_alpha <= p.src.alpha;
    dst_red   <= p.dst.red;
    dst_green <= p.dst.green;
    dst_blue  <= p.dst.blue;
    dst_alpha <= p.dst.alpha;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    blended_pixels.push_back(blend_over(p));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (blended_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    pixel_pair_t cases[$];
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    // fully transparent result, colors must come out as zero
    cases.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    cases.push_back(make_pair('1, '1, '1, 0, '1, '1, '1, 0));
    // opaque source wins outright
    cases.push_back(make_pair(16'h1234, 16'h5678, 16'h9abc, '1, 16'hfedc, 0, '1, 16'h8000));
    cases.push_back(make_pair(16'h0f0f, '1, 0, '1, '1, '1, '1, 0));
    // transparent source leaves the destination
    cases.push_back(make_pair('1, '1, '1, 0, 16'h4321, 16'h8765, 16'hcba9, '1));
    cases.push_back(make_pair('1, 0, '1, 0, 16'h00ff, 16'hff00, 16'h7fff, 16'h3333));
    cases.push_back(make_pair('1, '1, '1, '1, '1, '1, '1, '1));
    cases.push_back(make_pair('1, 16'h8000, 1, 1, 0, 0, 0, 0));
    cases.push_back(make_pair(0, 0, 0, 0, '1, 16'h8000, 1, 1));
    cases.push_back(make_pair(0, '1, 16'h5555, 16'hfffe, '1, 0, 16'haaaa, '1));
    cases.push_back(make_pair('1, '1, '1, 1, 0, 0, 0, '1));
    cases.push_back(make_pair('1, 0, '1, 16'h8000, 0, '1, 0, 16'h8000));
    cases.push_back(make_pair(0, 0, 0, '1, '1, '1, '1, '1));
    cases.push_back(make_pair('1, '1, '1, 16'h7fff, 0, 0, 0, '1));
    cases.push_back(make_pair(16'haaaa, 16'h5555, 16'haaaa, 16'hfffe,
                              16'h5555, 16'haaaa, 16'h5555, 16'hfffe));
    cases.push_back(make_pair('1, '1, '1, 1, 0, 0, 0, 1));
    foreach (cases[i]) send_pixel(cases[i]);
    wait_drained();
  endtask

  task automatic test_random_with_idling();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (1250) send_pixel(random_pair());
    wait_drained();
  endtask

  // Hold the output long enough that the pipeline fills and stalls the input.
  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    hold_request = 1'b1;
    repeat (80) send_pixel(random_pair());
    wait_drained();
  endtask

  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (600) send_pixel(random_pair());
    wait_drained();
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    rgba_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (blended_pixels.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h %h %h %h",
                                  out_red, out_green, out_blue, out_alpha));
      end else begin
        want = blended_pixels.pop_front();
        if (out_red !== want.red)
          report_mismatch($sformatf("red got %h, expected %h", out_red, want.red));
        if (out_green !== want.green)
          report_mismatch($sformatf("green got %h, expected %h", out_green, want.green));
        if (out_blue !== want.blue)
          report_mismatch($sformatf("blue got %h, expected %h", out_blue, want.blue));
        if (out_alpha !== want.alpha)
          report_mismatch($sformatf("alpha got %h, expected %h", out_alpha, want.alpha));
      end
      result_count++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             blended_pixels.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_with_idling();
    test_output_backpressure();
    test_full_rate();
    // catch any stray result after the last expected one
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
design/sao_pkg.sv
design/sao_front.sv
design/sao_divider.sv
design/straight_alpha_over_blend.sv
bench/straight_alpha_over_blend_tb.sv
